// ===== rtl/ewc_pkg.sv =====
// Shared types and constants for the ElGamal word cipher core.
// No dependencies; used by ewc_mulmod and elgamal_word_cipher_core.
package ewc_pkg;

    localparam int FIELD_W      = 31;
    localparam int MOD_BITS_DEF = 31;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_KEY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECRET_KEY = 2'd3;

    localparam logic [FIELD_W-1:0] MODULUS_RST    = 31'd3;
    localparam logic [FIELD_W-1:0] GENERATOR_RST  = 31'd2;
    localparam logic [FIELD_W-1:0] PUBLIC_KEY_RST = 31'd1;
    localparam logic [FIELD_W-1:0] SECRET_KEY_RST = 31'd0;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic               op;
        logic [FIELD_W-1:0] word_in;
        logic [FIELD_W-1:0] ephemeral;
        logic [FIELD_W-1:0] shared_part;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0] part_out;
        logic [FIELD_W-1:0] word_out;
    } t_out_beat;

endpackage

// ===== rtl/ewc_mulmod.sv =====
// Bit-serial modular multiplier: a * b mod p, one bit of b per cycle, MSB first.
// Depends on ewc_pkg. With a = 1 it reduces b mod p.
module ewc_mulmod #(
    parameter int MOD_BITS = ewc_pkg::MOD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [MOD_BITS-1:0]         i_a,
    input  logic [ewc_pkg::FIELD_W-1:0] i_b,
    input  logic [MOD_BITS-1:0]         i_p,
    output logic                        o_done,
    output logic [MOD_BITS-1:0]         o_res
);

    localparam int FW    = ewc_pkg::FIELD_W;
    localparam int TW    = MOD_BITS + 2;
    localparam int CNT_W = $clog2(FW + 1);

    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_a;
    logic [FW-1:0]       r_b;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [TW-1:0] t_sum;
    logic [TW-1:0] p1;
    logic [TW-1:0] p2;

    // acc stays below p, so 2*acc + a is below 3p: one of three picks reduces it
    always_comb begin
        p1    = TW'(i_p);
        p2    = TW'({i_p, 1'b0});
        t_sum = TW'({r_acc, 1'b0}) + (r_b[FW-1] ? TW'(r_a) : '0);
        if (t_sum >= p2) begin
            n_acc = MOD_BITS'(t_sum - p2);
        end else if (t_sum >= p1) begin
            n_acc = MOD_BITS'(t_sum - p1);
        end else begin
            n_acc = MOD_BITS'(t_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[FW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

// ===== rtl/elgamal_word_cipher_core.sv =====
// ElGamal word cipher core: encrypt or decrypt one word per input beat.
// Depends on ewc_pkg and ewc_mulmod (one shared bit-serial modular multiplier).
//
//   Channel   Direction   Handshake                 Beat
//   in        to core     i_in_valid / o_in_stall   ewc_pkg::t_in_beat
//   out       from core   o_out_valid / i_out_stall ewc_pkg::t_out_beat
//   cfg       to core     i_cfg_valid / o_cfg_ready index + 31-bit data
//
// Every modular product runs on the single multiplier.
// Encrypt: 3 reductions + 2 powers + 1 product; decrypt: 2 reductions + 2 powers
// + 1 product. A power costs 31 squarings plus one product per set exponent bit.
// A modulus below two skips all work and answers with zero in both fields.
// Reset is synchronous; registers return to p=3, g=2, h=1, x=0. One item is
// in work at a time; the output register holds a finished beat under stall
// while the next item is accepted and computed.
module elgamal_word_cipher_core #(
    parameter int MOD_BITS = ewc_pkg::MOD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ewc_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ewc_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ewc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ewc_pkg::FIELD_W-1:0]   i_cfg_data
);

    localparam int FW    = ewc_pkg::FIELD_W;
    localparam int BIT_W = $clog2(FW);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RW   = 3'd1;  // reduce word
    localparam logic [2:0] ST_RB   = 3'd2;  // reduce first base
    localparam logic [2:0] ST_P1   = 3'd3;  // first power
    localparam logic [2:0] ST_RH   = 3'd4;  // reduce public key
    localparam logic [2:0] ST_P2   = 3'd5;  // second power
    localparam logic [2:0] ST_FM   = 3'd6;  // final product
    localparam logic [2:0] ST_PUT  = 3'd7;  // hand result to output register

    logic [FW-1:0] r_mod, r_gen, r_pub, r_sec;

    logic [2:0]          r_state, n_state;
    logic                r_wait, n_wait;
    ewc_pkg::t_in_beat   r_in, n_in;
    logic [MOD_BITS-1:0] r_word, n_word;
    logic [MOD_BITS-1:0] r_base, n_base;
    logic [MOD_BITS-1:0] r_acc, n_acc;
    logic [MOD_BITS-1:0] r_part, n_part;
    logic [FW-1:0]       r_exp, n_exp;
    logic [BIT_W-1:0]    r_ebit, n_ebit;
    logic                r_sq, n_sq;
    logic                r_out_valid, n_out_valid;
    ewc_pkg::t_out_beat  r_out, n_out;

    logic [MOD_BITS-1:0] p;
    logic [MOD_BITS-1:0] p_m2;
    logic                mul_start;
    logic [MOD_BITS-1:0] mul_a;
    logic [FW-1:0]       mul_b;
    logic                mul_done;
    logic [MOD_BITS-1:0] mul_res;
    logic                step_go;
    logic                pow_last;

    assign p    = r_mod[MOD_BITS-1:0];
    assign p_m2 = p - MOD_BITS'(2);

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= ewc_pkg::MODULUS_RST;
            r_gen <= ewc_pkg::GENERATOR_RST;
            r_pub <= ewc_pkg::PUBLIC_KEY_RST;
            r_sec <= ewc_pkg::SECRET_KEY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ewc_pkg::CFG_MODULUS:    r_mod <= i_cfg_data;
                ewc_pkg::CFG_GENERATOR:  r_gen <= i_cfg_data;
                ewc_pkg::CFG_PUBLIC_KEY: r_pub <= i_cfg_data;
                ewc_pkg::CFG_SECRET_KEY: r_sec <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ewc_mulmod #(
        .MOD_BITS (MOD_BITS)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_p     (p),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_a = MOD_BITS'(1);
        mul_b = r_in.word_in;
        case (r_state)
            ST_RW: begin
                mul_b = r_in.word_in;
            end
            ST_RB: begin
                mul_b = (r_in.op == ewc_pkg::OP_DECRYPT) ? r_in.shared_part : r_gen;
            end
            ST_RH: begin
                mul_b = r_pub;
            end
            ST_P1, ST_P2: begin
                mul_a = r_acc;
                mul_b = r_sq ? FW'(r_acc) : FW'(r_base);
            end
            ST_FM: begin
                mul_a = r_word;
                mul_b = FW'(r_acc);
            end
            default: ;
        endcase
    end

    assign step_go  = r_wait && mul_done;
    // the bit is finished after its squaring when clear, after its product when set
    assign pow_last = (r_ebit == '0) && !(r_sq && r_exp[FW-1]);

    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        n_in        = r_in;
        n_word      = r_word;
        n_base      = r_base;
        n_acc       = r_acc;
        n_part      = r_part;
        n_exp       = r_exp;
        n_ebit      = r_ebit;
        n_sq        = r_sq;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_start   = 1'b0;

        if (r_state != ST_IDLE && r_state != ST_PUT && !r_wait) begin
            mul_start = 1'b1;
            n_wait    = 1'b1;
        end else if (step_go) begin
            n_wait = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in   = i_in_data;
                    n_part = '0;
                    if (p < MOD_BITS'(2)) begin
                        n_acc   = '0;
                        n_state = ST_PUT;
                    end else begin
                        n_state = ST_RW;
                    end
                end
            end
            ST_RW: begin
                if (step_go) begin
                    n_word  = mul_res;
                    n_state = ST_RB;
                end
            end
            ST_RB, ST_RH: begin
                if (step_go) begin
                    n_base  = mul_res;
                    n_acc   = MOD_BITS'(1);
                    n_ebit  = BIT_W'(FW - 1);
                    n_sq    = 1'b1;
                    if (r_state == ST_RH) begin
                        n_exp   = r_in.ephemeral;
                        n_state = ST_P2;
                    end else begin
                        n_exp   = (r_in.op == ewc_pkg::OP_DECRYPT) ? r_sec : r_in.ephemeral;
                        n_state = ST_P1;
                    end
                end
            end
            ST_P1, ST_P2: begin
                if (step_go) begin
                    n_acc = mul_res;
                    if (r_sq && r_exp[FW-1]) begin
                        n_sq = 1'b0;
                    end else begin
                        n_sq   = 1'b1;
                        n_exp  = {r_exp[FW-2:0], 1'b0};
                        n_ebit = r_ebit - BIT_W'(1);
                    end
                    if (pow_last) begin
                        if (r_state == ST_P2) begin
                            n_state = ST_FM;
                        end else if (r_in.op == ewc_pkg::OP_DECRYPT) begin
                            // invert the shared value: raise it to p-2
                            n_base  = mul_res;
                            n_acc   = MOD_BITS'(1);
                            n_exp   = FW'(p_m2);
                            n_ebit  = BIT_W'(FW - 1);
                            n_sq    = 1'b1;
                            n_state = ST_P2;
                        end else begin
                            n_part  = mul_res;
                            n_state = ST_RH;
                        end
                    end
                end
            end
            ST_FM: begin
                if (step_go) begin
                    n_acc   = mul_res;
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.part_out = FW'(r_part);
                    n_out.word_out = FW'(r_acc);
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_word <= n_word;
        r_base <= n_base;
        r_acc  <= n_acc;
        r_part <= n_part;
        r_exp  <= n_exp;
        r_ebit <= n_ebit;
        r_sq   <= n_sq;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
